/* rtl/core/arpc_pkg.sv */
package arpc_pkg;

   localparam int CACHE_ENTRIES = 16;
   localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
   localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int Q_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int Q_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic       OP_PACKET   = 1'b0;
   localparam logic       OP_LOOKUP   = 1'b1;
   localparam logic [1:0] OPC_REQUEST = 2'd0;
   localparam logic [1:0] OPC_REPLY   = 2'd1;

   typedef struct packed {
      logic        operation;
      logic [1:0]  opcode;
      logic [31:0] sender_ip;
      logic [47:0] sender_mac;
      logic [31:0] target_ip;
   } req_type;

   typedef struct packed {
      logic        reply_valid;
      logic [31:0] reply_sender_ip;
      logic [47:0] reply_sender_mac;
      logic [31:0] reply_target_ip;
      logic [47:0] reply_target_mac;
      logic        lookup_hit;
      logic [47:0] lookup_mac;
      logic        store_dropped;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_IGNORE,
      CMD_LOOKUP,
      CMD_REQUEST,
      CMD_STORE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [31:0]  key_ip;
      logic [31:0]  sender_ip;
      logic [47:0]  sender_mac;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SCAN,
      BK_EMIT
   } back_state_type;

endpackage

/* rtl/core/arpc_front.sv */
module arpc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  arpc_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_take,
   output arpc_pkg::cmd_type cmd
);

   localparam int Q_CNT_W = arpc_pkg::Q_CNT_W;
   localparam int Q_PTR_W = arpc_pkg::Q_PTR_W;

   arpc_pkg::cmd_type                 queue_ff [arpc_pkg::QUEUE_DEPTH];
   logic [arpc_pkg::Q_PTR_W-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [arpc_pkg::Q_PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [arpc_pkg::Q_CNT_W-1:0]      count_ff, count_in;
   arpc_pkg::cmd_type                 class_cmd;
   logic                              push_ok;
   logic                              pop_ok;

   // classify the incoming item into the work the back end must do
   always_comb begin
      class_cmd.kind       = arpc_pkg::CMD_IGNORE;
      class_cmd.key_ip     = req_data.target_ip;
      class_cmd.sender_ip  = req_data.sender_ip;
      class_cmd.sender_mac = req_data.sender_mac;
      if (req_data.operation == arpc_pkg::OP_LOOKUP) begin
         if (req_data.target_ip != 32'd0) begin
            class_cmd.kind = arpc_pkg::CMD_LOOKUP;
         end
      end else begin
         unique case (req_data.opcode)
            arpc_pkg::OPC_REQUEST: begin
               if (req_data.target_ip != 32'd0) begin
                  class_cmd.kind = arpc_pkg::CMD_REQUEST;
               end
            end
            arpc_pkg::OPC_REPLY: begin
               // search for the first empty slot
               class_cmd.kind   = arpc_pkg::CMD_STORE;
               class_cmd.key_ip = 32'd0;
            end
            default: class_cmd.kind = arpc_pkg::CMD_IGNORE;
         endcase
      end
   end

   assign req_full  = (count_ff == Q_CNT_W'(arpc_pkg::QUEUE_DEPTH));
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ? '0
                     : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(arpc_pkg::QUEUE_DEPTH - 1)) ? '0
                     : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         queue_ff[wr_ptr_ff] <= class_cmd;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= Q_CNT_W'(arpc_pkg::QUEUE_DEPTH))
      else $error("command queue over its depth");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_ok && !pop_ok) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("command queue count lost a push");

endmodule

/* rtl/core/arpc_back.sv */
module arpc_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_take,
   input  arpc_pkg::cmd_type cmd,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output arpc_pkg::rsp_type rsp_data
);

   localparam int IDX_W = arpc_pkg::IDX_W;
   localparam int CNT_W = arpc_pkg::CNT_W;

   logic [31:0]                        entry_ip_ff  [arpc_pkg::CACHE_ENTRIES];
   logic [47:0]                        entry_mac_ff [arpc_pkg::CACHE_ENTRIES];
   logic [arpc_pkg::CACHE_ENTRIES-1:0] entry_valid_ff;

   arpc_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   arpc_pkg::cmd_type        cmd_ff, cmd_in;
   logic                     hit_ff, hit_in;
   logic [47:0]              hit_mac_ff, hit_mac_in;
   logic                     res_valid_ff, res_valid_in;
   arpc_pkg::rsp_type        res_ff, res_in;

   logic [IDX_W-1:0]         rd_idx;
   logic [31:0]              rd_ip;
   logic [47:0]              rd_mac;
   logic                     wr_en;
   logic                     res_load;

   // an entry never written reads as empty
   assign rd_idx = idx_ff[IDX_W-1:0];
   assign rd_ip  = entry_valid_ff[rd_idx] ? entry_ip_ff[rd_idx]  : 32'd0;
   assign rd_mac = entry_valid_ff[rd_idx] ? entry_mac_ff[rd_idx] : 48'd0;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd_in       = cmd_ff;
      hit_in       = hit_ff;
      hit_mac_in   = hit_mac_ff;
      res_valid_in = res_valid_ff && !rsp_pop;
      res_in       = res_ff;
      cmd_take     = 1'b0;
      wr_en        = 1'b0;
      res_load     = 1'b0;
      unique case (state_ff)
         arpc_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_take   = 1'b1;
               cmd_in     = cmd;
               idx_in     = '0;
               hit_in     = 1'b0;
               hit_mac_in = 48'd0;
               state_in   = (cmd.kind == arpc_pkg::CMD_IGNORE) ? arpc_pkg::BK_EMIT
                            : arpc_pkg::BK_SCAN;
            end
         end
         arpc_pkg::BK_SCAN: begin
            // walk one entry a cycle; stop at the lowest match
            if (rd_ip == cmd_ff.key_ip) begin
               hit_in     = 1'b1;
               hit_mac_in = rd_mac;
               wr_en      = (cmd_ff.kind == arpc_pkg::CMD_STORE);
               state_in   = arpc_pkg::BK_EMIT;
            end else if (idx_ff == CNT_W'(arpc_pkg::CACHE_ENTRIES - 1)) begin
               state_in = arpc_pkg::BK_EMIT;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         arpc_pkg::BK_EMIT: begin
            // hold until the output register is free
            if (!res_valid_ff || rsp_pop) begin
               res_load     = 1'b1;
               res_valid_in = 1'b1;
               res_in       = '0;
               unique case (cmd_ff.kind)
                  arpc_pkg::CMD_LOOKUP: begin
                     res_in.lookup_hit = hit_ff;
                     res_in.lookup_mac = hit_mac_ff;
                  end
                  arpc_pkg::CMD_REQUEST: begin
                     if (hit_ff) begin
                        res_in.reply_valid      = 1'b1;
                        res_in.reply_sender_ip  = cmd_ff.key_ip;
                        res_in.reply_sender_mac = hit_mac_ff;
                        res_in.reply_target_ip  = cmd_ff.sender_ip;
                        res_in.reply_target_mac = cmd_ff.sender_mac;
                     end
                  end
                  arpc_pkg::CMD_STORE: res_in.store_dropped = !hit_ff;
                  arpc_pkg::CMD_IGNORE: res_in = '0;
                  default: res_in = '0;
               endcase
               state_in = arpc_pkg::BK_IDLE;
            end
         end
         default: state_in = arpc_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= arpc_pkg::BK_IDLE;
         res_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         state_ff     <= state_in;
         res_valid_ff <= res_valid_in;
         if (wr_en) begin
            entry_valid_ff[rd_idx] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmd_ff     <= cmd_in;
      hit_ff     <= hit_in;
      hit_mac_ff <= hit_mac_in;
      res_ff     <= res_in;
      if (wr_en) begin
         entry_ip_ff[rd_idx]  <= cmd_ff.sender_ip;
         entry_mac_ff[rd_idx] <= cmd_ff.sender_mac;
      end
   end

   assign rsp_empty = !res_valid_ff;
   assign rsp_data  = res_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == arpc_pkg::BK_SCAN) |-> (idx_ff < CNT_W'(arpc_pkg::CACHE_ENTRIES)))
      else $error("cache walk beyond last entry");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      res_load |-> (!res_valid_ff || rsp_pop))
      else $error("result overwritten before transfer");

   a_one_flag: assert property (@(posedge clock) disable iff (reset)
      res_valid_ff |->
         ($countones({res_ff.reply_valid, res_ff.lookup_hit, res_ff.store_dropped}) <= 1))
      else $error("result carries more than one outcome");

   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> (state_ff != arpc_pkg::BK_IDLE))
      else $error("command taken but back end stayed idle");

endmodule

/* rtl/core/arp_cache_responder.sv */
// ARP cache and responder.
// Input side is a queue: drive req_data and raise req_push; the item transfers
// at a clock edge where req_full is low. Each item yields exactly one result.
// Result side is a queue too: while rsp_empty is low the oldest result sits on
// rsp_data, and it transfers at an edge where rsp_pop is high.
// A received request that hits the cache gives a reply, a received reply is
// stored in the first empty slot (store_dropped when none is left), and a
// lookup returns the cached MAC for a nonzero IP.
// Items are classified on entry and held in a two-deep command queue; the back
// end walks the cache one entry per cycle and stops at the first match, while
// an ignored item skips the walk. Items are served one at a time: the next
// command is taken only after the last result is loaded into the output
// register.
// A finished result waits in the output register while the sender keeps
// pushing into the command queue; when the receiver stalls the queue fills
// and req_full rises.
// Synchronous reset empties both queues and marks every cache entry empty;
// no clearing pass is needed, so items are taken in the first cycle after.
module arp_cache_responder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  arpc_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output arpc_pkg::rsp_type rsp_data
);

   logic              cmd_valid;
   logic              cmd_take;
   arpc_pkg::cmd_type cmd;

   arpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd)
   );

   arpc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_take  (cmd_take),
      .cmd       (cmd),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/arp_cache_tracker.sv */
`timescale 1ns / 1ps
module arp_cache_tracker (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  arpc_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  arpc_pkg::rsp_type rsp_data,
   output int                fail_count,
   output int                answers_due
);

   logic [31:0]       slot_ip  [arpc_pkg::CACHE_ENTRIES];
   logic [47:0]       slot_mac [arpc_pkg::CACHE_ENTRIES];
   arpc_pkg::rsp_type due_answers[$];
   arpc_pkg::rsp_type want;

   // lowest-numbered slot holding ip, or -1
   function automatic int first_slot(input logic [31:0] ip);
      for (int i = 0; i < arpc_pkg::CACHE_ENTRIES; i++) begin
         if (slot_ip[i] == ip) return i;
      end
      return -1;
   endfunction

   function automatic arpc_pkg::rsp_type resolve_arp(input arpc_pkg::req_type item);
      arpc_pkg::rsp_type res;
      int                hit;
      res = '0;
      if (item.operation == arpc_pkg::OP_LOOKUP) begin
         hit = (item.target_ip != 32'd0) ? first_slot(item.target_ip) : -1;
         if (hit >= 0) begin
            res.lookup_hit = 1'b1;
            res.lookup_mac = slot_mac[hit];
         end
      end else if (item.opcode == arpc_pkg::OPC_REQUEST) begin
         hit = (item.target_ip != 32'd0) ? first_slot(item.target_ip) : -1;
         if (hit >= 0) begin
            res.reply_valid      = 1'b1;
            res.reply_sender_ip  = item.target_ip;
            res.reply_sender_mac = slot_mac[hit];
            res.reply_target_ip  = item.sender_ip;
            res.reply_target_mac = item.sender_mac;
         end
      end else if (item.opcode == arpc_pkg::OPC_REPLY) begin
         // no duplicate check; an IP of zero leaves the slot empty
         hit = first_slot(32'd0);
         if (hit >= 0) begin
            slot_ip[hit]  = item.sender_ip;
            slot_mac[hit] = item.sender_mac;
         end else begin
            res.store_dropped = 1'b1;
         end
      end
      return res;
   endfunction

   task automatic check_field(input string name, input logic [47:0] exp, input logic [47:0] act);
      if (exp !== act) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp, act);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < arpc_pkg::CACHE_ENTRIES; i++) begin
            slot_ip[i]  = '0;
            slot_mac[i] = '0;
         end
         due_answers.delete();
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (due_answers.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: result transfer with none due, got %h", $time, rsp_data);
            end else begin
               want = due_answers.pop_front();
               check_field("reply_valid", want.reply_valid, rsp_data.reply_valid);
               check_field("reply_sender_ip", want.reply_sender_ip, rsp_data.reply_sender_ip);
               check_field("reply_sender_mac", want.reply_sender_mac,
                           rsp_data.reply_sender_mac);
               check_field("reply_target_ip", want.reply_target_ip, rsp_data.reply_target_ip);
               check_field("reply_target_mac", want.reply_target_mac,
                           rsp_data.reply_target_mac);
               check_field("lookup_hit", want.lookup_hit, rsp_data.lookup_hit);
               check_field("lookup_mac", want.lookup_mac, rsp_data.lookup_mac);
               check_field("store_dropped", want.store_dropped, rsp_data.store_dropped);
            end
         end
         if (req_push && !req_full) due_answers.push_back(resolve_arp(req_data));
      end
      answers_due = due_answers.size();
   end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

   localparam logic [1:0]  OPC_SPARE_LO = 2'd2;
   localparam logic [1:0]  OPC_SPARE_HI = 2'd3;
   localparam int          RANDOM_ITEMS = 1600;
   localparam logic [31:0] HOST_A       = 32'h0A00_0001;
   localparam logic [31:0] IP_ONES      = 32'hFFFF_FFFF;
   localparam logic [47:0] MAC_ONES     = 48'hFFFF_FFFF_FFFF;
   localparam logic [47:0] MAC_FIRST    = 48'h0200_0000_0001;
   localparam logic [47:0] MAC_SECOND   = 48'h0200_0000_0002;

   typedef enum int {
      POP_ALWAYS,
      POP_HALF,
      POP_SPARSE,
      POP_RARE
   } pop_pattern_type;

   logic              clock    = 1'b0;
   logic              reset    = 1'b1;
   logic              req_push = 1'b0;
   logic              req_full;
   arpc_pkg::req_type req_data = '0;
   logic              rsp_empty;
   logic              rsp_pop  = 1'b0;
   arpc_pkg::rsp_type rsp_data;
   int                fail_count;
   int                answers_due;

   logic [31:0] known_ips[$];

   arp_cache_responder uut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

   arp_cache_tracker tracker (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .answers_due (answers_due)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic arpc_pkg::req_type arp_item(input logic op, input logic [1:0] opc,
                                                  input logic [31:0] sip,
                                                  input logic [47:0] smac,
                                                  input logic [31:0] tip);
      arpc_pkg::req_type item;
      item.operation  = op;
      item.opcode     = opc;
      item.sender_ip  = sip;
      item.sender_mac = smac;
      item.target_ip  = tip;
      return item;
   endfunction

   // offer one item and hold it until it transfers; push stays high afterwards
   task automatic push_item(input arpc_pkg::req_type item);
      req_data = item;
      req_push = 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      if (item.operation == arpc_pkg::OP_PACKET && item.opcode == arpc_pkg::OPC_REPLY &&
          item.sender_ip != 32'd0 && known_ips.size() < 24)
         known_ips.push_back(item.sender_ip);
   endtask

   initial begin
      arpc_pkg::req_type item;
      int                burst;
      int                gap;
      int                kind;
      int                pick;
      int                counted;
      logic [63:0]       wide;
      logic [31:0]       tip;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty cache: every search misses
      push_item(arp_item(arpc_pkg::OP_LOOKUP, arpc_pkg::OPC_REQUEST, 32'd0, 48'd0, 32'd0));
      push_item(arp_item(arpc_pkg::OP_LOOKUP, arpc_pkg::OPC_REPLY, IP_ONES, MAC_ONES,
                         IP_ONES));
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REQUEST, IP_ONES, MAC_ONES,
                         32'd0));
      // reply from IP zero: MAC lands in slot 0, slot stays empty
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REPLY, 32'd0, MAC_ONES, 32'd0));
      push_item(arp_item(arpc_pkg::OP_LOOKUP, arpc_pkg::OPC_REQUEST, 32'd0, 48'd0, 32'd0));
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REQUEST, HOST_A, MAC_FIRST,
                         32'd0));
      // duplicate stores: the lower slot must win
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REPLY, HOST_A, MAC_FIRST, 32'd0));
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REPLY, HOST_A, MAC_SECOND,
                         IP_ONES));
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REQUEST, IP_ONES, MAC_ONES,
                         HOST_A));
      push_item(arp_item(arpc_pkg::OP_LOOKUP, arpc_pkg::OPC_REQUEST, 32'd0, 48'd0, HOST_A));
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REPLY, IP_ONES, 48'd0, IP_ONES));
      push_item(arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REQUEST, 32'd0, 48'd0, IP_ONES));
      push_item(arp_item(arpc_pkg::OP_LOOKUP, OPC_SPARE_HI, IP_ONES, MAC_ONES, IP_ONES));
      // ignored packet kinds give an all-zero result, while a lookup ignores its opcode
      push_item(arp_item(arpc_pkg::OP_PACKET, OPC_SPARE_LO, HOST_A, MAC_FIRST, HOST_A));
      push_item(arp_item(arpc_pkg::OP_PACKET, OPC_SPARE_HI, IP_ONES, MAC_ONES, HOST_A));
      push_item(arp_item(arpc_pkg::OP_LOOKUP, OPC_SPARE_LO, 32'd0, 48'd0, HOST_A));
      push_item(arp_item(arpc_pkg::OP_LOOKUP, arpc_pkg::OPC_REPLY, HOST_A, MAC_ONES,
                         32'h0A00_0002));

      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 30);
         repeat (burst) begin
            kind = $urandom_range(0, 99);
            pick = $urandom_range(0, 9);
            if (pick < 7 && known_ips.size() > 0)
               tip = known_ips[$urandom_range(0, known_ips.size() - 1)];
            else if (pick == 7)
               tip = 32'd0;
            else
               tip = $urandom;
            wide = {$urandom, $urandom};
            item = arp_item(arpc_pkg::OP_PACKET, arpc_pkg::OPC_REQUEST, $urandom,
                            wide[47:0], tip);
            if (kind < 35) begin
               item.operation = arpc_pkg::OP_LOOKUP;
               item.opcode    = 2'($urandom_range(0, 3));
            end else if (kind >= 70 && kind < 85) begin
               item.opcode = arpc_pkg::OPC_REPLY;
               pick = $urandom_range(0, 7);
               if (pick == 0)
                  item.sender_ip = 32'd0;
               else if (pick == 1 && known_ips.size() > 0)
                  item.sender_ip = known_ips[$urandom_range(0, known_ips.size() - 1)];
            end else if (kind >= 85) begin
               item.opcode = 2'($urandom_range(OPC_SPARE_LO, OPC_SPARE_HI));
            end
            push_item(item);
            counted++;
         end
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
         if (gap > 0) begin
            req_push = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_push = 1'b0;

      wait (answers_due == 0);
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

   initial begin
      pop_pattern_type pattern;
      int              span;

      @(negedge clock);
      while (reset) @(negedge clock);
      repeat (150) begin
         rsp_pop = 1'($urandom_range(0, 1));
         @(negedge clock);
      end
      // hold off long enough for the command queue to fill and req_full to rise
      rsp_pop = 1'b0;
      repeat (400) @(negedge clock);
      forever begin
         pattern = pop_pattern_type'($urandom_range(0, 3));
         span    = $urandom_range(20, 200);
         repeat (span) begin
            case (pattern)
               POP_ALWAYS: rsp_pop = 1'b1;
               POP_HALF:   rsp_pop = 1'($urandom_range(0, 1));
               POP_SPARSE: rsp_pop = ($urandom_range(0, 3) == 0);
               default:    rsp_pop = ($urandom_range(0, 49) == 0);
            endcase
            @(negedge clock);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
